### design/ffba_pkg.sv
// ----------------------------------------------------------------------------
// First-fit block allocator: shared package
// Sizes, status codes and the item and block table types used by the
// allocator and its block table.
// ----------------------------------------------------------------------------
package ffba_pkg;

    // Block table and heap geometry
    localparam int MAX_BLOCKS   = 256;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
    localparam int SIZE_W       = 24;
    localparam int ADDR_W       = 32;
    localparam int STAT_W       = 3;
    localparam int HEAP_BYTES   = 8388608;
    localparam int HEADER_BYTES = 8;

    localparam logic [ADDR_W-1:0] PAGE_MASK = 32'h0000_0FFF;

    // Request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STAT_W-1:0] STAT_ZERO    = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NOMEM   = 3'd2;
    localparam logic [STAT_W-1:0] STAT_FULL    = 3'd3;
    localparam logic [STAT_W-1:0] STAT_IGNORED = 3'd4;

    // Request item
    typedef struct packed {
        logic              req_type;
        logic [SIZE_W-1:0] req_size;
        logic [ADDR_W-1:0] block_addr;
    } t_req;

    // Result item
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] payload_addr;
        logic [SIZE_W-1:0] used_bytes;
    } t_res;

    // Block table write port
    typedef struct packed {
        logic              we;
        logic              we_size;
        logic [IDX_W-1:0]  addr;
        logic [SIZE_W-1:0] size;
        logic              busy;
    } t_tbl_wr;

    // Block table read data
    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic              busy;
    } t_tbl_rd;

endpackage

### design/ffba_table.sv
// ----------------------------------------------------------------------------
// First-fit block allocator: block table
// One write port and one registered read port over the block size and busy
// stores. Entries hold nothing meaningful until written.
// ----------------------------------------------------------------------------
module ffba_table (
    input  logic                       i_clk,
    input  logic [ffba_pkg::IDX_W-1:0] i_rd_addr,
    input  ffba_pkg::t_tbl_wr          i_wr,
    output ffba_pkg::t_tbl_rd          o_rd
);
    import ffba_pkg::*;

    logic [SIZE_W-1:0] r_size_mem [MAX_BLOCKS];
    logic              r_busy_mem [MAX_BLOCKS];
    t_tbl_rd           r_rd;

    // Write the busy mark, and the size when a block is appended
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_busy_mem[i_wr.addr] <= i_wr.busy;
            if (i_wr.we_size) begin
                r_size_mem[i_wr.addr] <= i_wr.size;
            end
        end
    end

    // Register the read data
    always_ff @(posedge i_clk) begin
        r_rd.size <= r_size_mem[i_rd_addr];
        r_rd.busy <= r_busy_mem[i_rd_addr];
    end

    assign o_rd = r_rd;

endmodule

### design/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// First-fit block allocator
// Allocates and frees heap blocks kept in a block table, reusing the first
// free block that is large enough, or appending a new block at the heap top.
// ----------------------------------------------------------------------------
//  channel   signals                       handshake
//  request   start, i_req (t_req)          taken when start high, busy low
//  result    o_strobe, o_res (t_res)       one cycle, strobe high, no stall
//  config    i_cfg_we, i_cfg_wdata         image_end written when we high
//
//  A request reads table entries in order, up to the first match, or all of
//  block_count on a miss. The single table read port reads one entry a
//  cycle. A zero-size allocate or a null free skips the table scan.
//  Reset is synchronous; the table needs no clearing.
//  The receiver cannot stall, so each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module first_fit_block_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  ffba_pkg::t_req              i_req,
    output logic                        busy,
    output logic                        o_strobe,
    output ffba_pkg::t_res              o_res,
    input  logic                        i_cfg_we,
    input  logic [ffba_pkg::ADDR_W-1:0] i_cfg_wdata
);
    import ffba_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam int NEED_W = SIZE_W + 2;

    localparam logic [SIZE_W-1:0] HDR      = SIZE_W'(HEADER_BYTES);
    localparam logic [NEED_W-1:0] HDR_N    = NEED_W'(HEADER_BYTES);
    localparam logic [NEED_W-1:0] HEAP_N   = NEED_W'(HEAP_BYTES);
    localparam logic [ADDR_W-1:0] HDR_A    = ADDR_W'(HEADER_BYTES);
    localparam logic [ADDR_W-1:0] IMG_RST  = 32'h0010_0000;
    localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_BLOCKS);

    // Control registers
    logic [1:0]        r_state,     n_state;
    logic [CNT_W-1:0]  r_count,     n_count;
    logic [SIZE_W-1:0] r_top,       n_top;
    logic [SIZE_W-1:0] r_used,      n_used;
    logic [ADDR_W-1:0] r_image_end, n_image_end;
    logic              r_chk_vld,   n_chk_vld;
    logic              r_found,     n_found;
    logic              r_strobe,    n_strobe;

    // Per-item working registers
    t_req              r_req,       n_req;
    logic [ADDR_W-1:0] r_base8,     n_base8;
    logic [CNT_W-1:0]  r_idx,       n_idx;
    logic [IDX_W-1:0]  r_chk_idx,   n_chk_idx;
    logic [SIZE_W-1:0] r_off,       n_off;
    logic [IDX_W-1:0]  r_hit_idx,   n_hit_idx;
    logic [SIZE_W-1:0] r_hit_size,  n_hit_size;
    logic              r_hit_busy,  n_hit_busy;
    logic [SIZE_W-1:0] r_hit_off,   n_hit_off;
    t_res              r_res,       n_res;

    t_tbl_wr           tbl_wr;
    t_tbl_rd           tbl_rd;

    logic              issue;
    logic              scan_hit;
    logic [SIZE_W-1:0] off_sel;
    logic [ADDR_W-1:0] addr_sum;
    logic [SIZE_W-1:0] span;
    logic [NEED_W-1:0] heap_need;
    logic              heap_over;
    logic [ADDR_W-1:0] base_align;

    ffba_table u_table (
        .i_clk     (i_clk),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .i_wr      (tbl_wr),
        .o_rd      (tbl_rd)
    );

    // Shared address adder: entry address while scanning, result otherwise
    assign off_sel  = (r_state == S_SCAN) ? r_off : (r_found ? r_hit_off : r_top);
    assign addr_sum = r_base8 + ADDR_W'(off_sel);

    // Entry match for the current request kind
    assign scan_hit = (r_req.req_type == REQ_FREE) ?
                      (addr_sum == r_req.block_addr) :
                      (!tbl_rd.busy && (tbl_rd.size >= r_req.req_size));
    assign issue    = r_idx < r_count;

    // Block span of the reused, freed or appended block
    assign span      = (r_found ? r_hit_size : r_req.req_size) + HDR;
    assign heap_need = NEED_W'(r_top) + HDR_N + NEED_W'(r_req.req_size);
    assign heap_over = heap_need > HEAP_N;

    assign base_align = (r_image_end + PAGE_MASK) & ~PAGE_MASK;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_top       = r_top;
        n_used      = r_used;
        n_image_end = r_image_end;
        n_chk_vld   = r_chk_vld;
        n_found     = r_found;
        n_strobe    = 1'b0;
        n_req       = r_req;
        n_base8     = r_base8;
        n_idx       = r_idx;
        n_chk_idx   = r_chk_idx;
        n_off       = r_off;
        n_hit_idx   = r_hit_idx;
        n_hit_size  = r_hit_size;
        n_hit_busy  = r_hit_busy;
        n_hit_off   = r_hit_off;
        n_res       = r_res;
        tbl_wr      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req     = i_req;
                    n_base8   = base_align + HDR_A;
                    n_idx     = '0;
                    n_chk_vld = 1'b0;
                    n_off     = '0;
                    n_found   = 1'b0;
                    if ((i_req.req_type == REQ_ALLOC && i_req.req_size == '0) ||
                        (i_req.req_type == REQ_FREE && i_req.block_addr == '0)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_chk_vld && scan_hit) begin
                    // Hold the matching entry and stop
                    n_found    = 1'b1;
                    n_hit_idx  = r_chk_idx;
                    n_hit_size = tbl_rd.size;
                    n_hit_busy = tbl_rd.busy;
                    n_hit_off  = r_off;
                    n_chk_vld  = 1'b0;
                    n_state    = S_DONE;
                end else begin
                    // Advance the offset past a checked entry, issue the next read
                    if (r_chk_vld) begin
                        n_off = r_off + tbl_rd.size + HDR;
                    end
                    n_chk_vld = issue;
                    n_chk_idx = r_idx[IDX_W-1:0];
                    if (issue) begin
                        n_idx = r_idx + CNT_W'(1);
                    end
                    if (!r_chk_vld && !issue) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                n_strobe           = 1'b1;
                n_state            = S_IDLE;
                n_res.payload_addr = '0;
                n_res.status       = STAT_IGNORED;
                if (r_req.req_type == REQ_ALLOC) begin
                    if (r_req.req_size == '0) begin
                        n_res.status = STAT_ZERO;
                    end else if (r_found) begin
                        // Reuse the free block without splitting it
                        n_res.status       = STAT_OK;
                        n_res.payload_addr = addr_sum;
                        n_used             = r_used + span;
                        tbl_wr.we          = 1'b1;
                        tbl_wr.addr        = r_hit_idx;
                        tbl_wr.busy        = 1'b1;
                    end else if (heap_over) begin
                        n_res.status = STAT_NOMEM;
                    end else if (r_count >= CNT_MAX) begin
                        n_res.status = STAT_FULL;
                    end else begin
                        // Append a block at the heap top
                        n_res.status       = STAT_OK;
                        n_res.payload_addr = addr_sum;
                        n_used             = r_used + span;
                        n_top              = r_top + span;
                        n_count            = r_count + CNT_W'(1);
                        tbl_wr.we          = 1'b1;
                        tbl_wr.we_size     = 1'b1;
                        tbl_wr.addr        = r_count[IDX_W-1:0];
                        tbl_wr.size        = r_req.req_size;
                        tbl_wr.busy        = 1'b1;
                    end
                end else if (r_found && r_hit_busy) begin
                    // Release the busy block
                    n_res.status = STAT_OK;
                    n_used       = r_used - span;
                    tbl_wr.we    = 1'b1;
                    tbl_wr.addr  = r_hit_idx;
                    tbl_wr.busy  = 1'b0;
                end
                n_res.used_bytes = n_used;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_image_end = i_cfg_wdata;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_top       <= '0;
            r_used      <= '0;
            r_image_end <= IMG_RST;
            r_chk_vld   <= 1'b0;
            r_found     <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_top       <= n_top;
            r_used      <= n_used;
            r_image_end <= n_image_end;
            r_chk_vld   <= n_chk_vld;
            r_found     <= n_found;
            r_strobe    <= n_strobe;
        end
    end

    // Working and result registers
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_base8    <= n_base8;
        r_idx      <= n_idx;
        r_chk_idx  <= n_chk_idx;
        r_off      <= n_off;
        r_hit_idx  <= n_hit_idx;
        r_hit_size <= n_hit_size;
        r_hit_busy <= n_hit_busy;
        r_hit_off  <= n_hit_off;
        r_res      <= n_res;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    // Each result follows the completion state
    a_strobe_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state) == S_DONE)
        else $error("result strobe without completion");

    // The block count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("block count beyond table depth");

    // An accepted request makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // A non-null payload address only comes with a successful status
    a_addr_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.payload_addr != '0) |-> o_res.status == STAT_OK)
        else $error("payload address on failed request");

    // The table is written only when a result is being completed
    a_write_in_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_wr.we |-> (r_state == S_DONE && n_strobe))
        else $error("table write outside completion");

endmodule
